// ===== rtl/mcr_pkg.sv =====
// Shared types, codes and constants of the midpoint circle rasterizer.
package mcr_pkg;

  localparam int COORD_BITS_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CTR_W     = 10;
  localparam int RAD_W     = 9;
  localparam int DIM_W     = 11;
  localparam int PIX_W     = 12;
  localparam int DEC_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_IDX_W = 3;

  localparam logic [DIM_W-1:0] IMG_DIM_RESET = 11'd750;

  localparam logic [DEC_W-1:0] DEC_INIT     = 16'd3;
  localparam logic [DEC_W-1:0] DEC_STEP_IN  = 16'd6;
  localparam logic [DEC_W-1:0] DEC_STEP_OUT = 16'd10;

  localparam logic [PIX_IDX_W-1:0] PIX_IDX_LAST = 3'd7;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic in_image;
    logic last_of_point;
    logic circle_done;
  } pix_flags_t;

endpackage

// ===== rtl/mcr_front.sv =====
// Front end: holds the circle state, applies start and step items, emits point records.
module mcr_front import mcr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_accept,
  input  logic                  req_type,
  input  logic [CTR_W-1:0]      center_x,
  input  logic [CTR_W-1:0]      center_y,
  input  logic [RAD_W-1:0]      radius,
  output logic                  pt_valid,
  output logic [COORD_BITS-1:0] pt_cx,
  output logic [COORD_BITS-1:0] pt_cy,
  output logic [COORD_BITS-1:0] pt_a,
  output logic [COORD_BITS-1:0] pt_b,
  output logic                  pt_done
);

  localparam int AW = COORD_BITS + 1;
  localparam int BW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] centre_col_r, centre_col_nxt;
  logic [COORD_BITS-1:0] centre_row_r, centre_row_nxt;
  logic [COORD_BITS-1:0] offset_a_r, offset_a_nxt;
  logic [COORD_BITS-1:0] offset_b_r, offset_b_nxt;
  logic [DEC_W-1:0]      decision_r, decision_nxt;
  logic                  active_r, active_nxt;

  logic                  is_start;
  logic                  dec_neg;
  logic [AW-1:0]         a_inc;
  logic signed [BW-1:0]  b_upd;
  logic                  done_step;
  logic [DEC_W-1:0]      dec_upd;
  logic [COORD_BITS-1:0] rad_c;

  assign is_start = (req_t'(req_type) == REQ_START);
  assign dec_neg  = decision_r[DEC_W-1];
  assign rad_c    = COORD_BITS'(radius);

  always_comb begin
    a_inc     = AW'(offset_a_r) + AW'(1);
    b_upd     = dec_neg ? $signed(BW'(offset_b_r)) : $signed(BW'(offset_b_r) - BW'(1));
    done_step = $signed({1'b0, a_inc}) > b_upd;
    if (dec_neg) begin
      dec_upd = decision_r + (DEC_W'(offset_a_r) << 2) + DEC_STEP_IN;
    end else begin
      dec_upd = decision_r + ((DEC_W'(offset_a_r) - DEC_W'(offset_b_r)) << 2) + DEC_STEP_OUT;
    end
  end

  always_comb begin
    centre_col_nxt = centre_col_r;
    centre_row_nxt = centre_row_r;
    offset_a_nxt   = offset_a_r;
    offset_b_nxt   = offset_b_r;
    decision_nxt   = decision_r;
    active_nxt     = active_r;
    if (item_accept) begin
      if (is_start) begin
        centre_col_nxt = COORD_BITS'(center_x);
        centre_row_nxt = COORD_BITS'(center_y);
        offset_a_nxt   = '0;
        offset_b_nxt   = rad_c;
        decision_nxt   = DEC_INIT - (DEC_W'(rad_c) << 1);
        active_nxt     = 1'b1;
      end else if (active_r) begin
        offset_a_nxt = a_inc[COORD_BITS-1:0];
        offset_b_nxt = b_upd[COORD_BITS-1:0];
        decision_nxt = dec_upd;
        active_nxt   = !done_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_col_r <= '0;
      centre_row_r <= '0;
      offset_a_r   <= '0;
      offset_b_r   <= '0;
      decision_r   <= '0;
      active_r     <= 1'b0;
    end else begin
      centre_col_r <= centre_col_nxt;
      centre_row_r <= centre_row_nxt;
      offset_a_r   <= offset_a_nxt;
      offset_b_r   <= offset_b_nxt;
      decision_r   <= decision_nxt;
      active_r     <= active_nxt;
    end
  end

  // A step item snapshots the point before the state moves on.
  assign pt_valid = item_accept && !is_start && active_r;
  assign pt_cx    = centre_col_r;
  assign pt_cy    = centre_row_r;
  assign pt_a     = offset_a_r;
  assign pt_b     = offset_b_r;
  assign pt_done  = done_step;

endmodule

// ===== rtl/mcr_queue.sv =====
// Small register-based FIFO of point records between front and back end.
module mcr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/mcr_back.sv =====
// Back end: walks the eight symmetric pixels of each point into the output register.
module mcr_back import mcr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic [COORD_BITS-1:0] q_cx,
  input  logic [COORD_BITS-1:0] q_cy,
  input  logic [COORD_BITS-1:0] q_a,
  input  logic [COORD_BITS-1:0] q_b,
  input  logic                  q_done,
  output logic                  q_pop,
  input  logic [DIM_W-1:0]      img_width,
  input  logic [DIM_W-1:0]      img_height,
  input  logic                  out_pop,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_pixel_x,
  output logic [PIX_W-1:0]      out_pixel_y,
  output pix_flags_t            out_flags
);

  localparam int PW = COORD_BITS + 2;
  localparam int CW = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;

  logic                  busy_r, busy_nxt;
  logic [PIX_IDX_W-1:0]  idx_r, idx_nxt;
  logic [COORD_BITS-1:0] cx_r, cy_r, a_r, b_r;
  logic                  done_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]      pix_x_r, pix_y_r;
  pix_flags_t            flags_r;

  logic                  adv;
  logic                  at_last;
  logic                  load;
  logic [COORD_BITS-1:0] xo, yo;
  logic signed [PW-1:0]  px, py;
  logic                  x_in, y_in;
  pix_flags_t            flags_nxt;

  assign at_last = (idx_r == PIX_IDX_LAST);
  assign adv     = busy_r && (!out_valid_r || out_pop);
  assign load    = q_valid && (!busy_r || (adv && at_last));
  assign q_pop   = load;

  // Bit 2 of the index swaps the offsets, bits 0 and 1 negate x and y.
  always_comb begin
    xo = idx_r[2] ? b_r : a_r;
    yo = idx_r[2] ? a_r : b_r;
    px = idx_r[0] ? $signed(PW'(cx_r) - PW'(xo)) : $signed(PW'(cx_r) + PW'(xo));
    py = idx_r[1] ? $signed(PW'(cy_r) - PW'(yo)) : $signed(PW'(cy_r) + PW'(yo));
    x_in = !px[PW-1] && (CW'(px[PW-2:0]) < CW'(img_width));
    y_in = !py[PW-1] && (CW'(py[PW-2:0]) < CW'(img_height));
    flags_nxt.in_image      = x_in && y_in;
    flags_nxt.last_of_point = at_last;
    flags_nxt.circle_done   = at_last && done_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (adv) begin
      busy_nxt = !at_last;
      idx_nxt  = idx_r + PIX_IDX_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cx_r   <= q_cx;
      cy_r   <= q_cy;
      a_r    <= q_a;
      b_r    <= q_b;
      done_r <= q_done;
    end
    if (adv) begin
      pix_x_r <= PIX_W'(px);
      pix_y_r <= PIX_W'(py);
      flags_r <= flags_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = pix_x_r;
  assign out_pixel_y = pix_y_r;
  assign out_flags   = flags_r;

endmodule

// ===== rtl/midpoint_circle_rasterizer_unit.sv =====
// Top level of the midpoint circle rasterizer: front end, point queue, pixel back end.
//
// A start item (req_type 0) latches centre and radius when accepted and produces no
// pixels; each step item (req_type 1) produces the eight symmetric pixels of the
// current point, one transfer per cycle while the receiver pops, so a circle streams
// at one pixel per clock unless the output is held. That rate is set by the back-end
// pixel sequencer, which walks the eight symmetric positions of one queued point
// through a single adder pair. The front end updates the decision value in the cycle
// it accepts an item and hands a point snapshot into a two-entry queue, so step items
// may arrive in consecutive cycles until the queue fills; full then holds off new
// items (start items included) until the back end frees a slot. The single output
// register holds the oldest pixel until pop; while it waits, the back end stalls and
// the queue absorbs further step items. A step with
// no circle in progress is swallowed with no pixels. The image size registers are
// written through the cfg port, which is always ready; write them only while idle.
module midpoint_circle_rasterizer_unit import mcr_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_req_type,
  input  logic [CTR_W-1:0]     in_center_x,
  input  logic [CTR_W-1:0]     in_center_y,
  input  logic [RAD_W-1:0]     in_radius,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [PIX_W-1:0] out_pixel_x,
  output logic signed [PIX_W-1:0] out_pixel_y,
  output logic                 out_in_image,
  output logic                 out_last_of_point,
  output logic                 out_circle_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int QW = 4 * COORD_BITS + 1;

  logic [DIM_W-1:0] img_width_r, img_width_nxt;
  logic [DIM_W-1:0] img_height_r, img_height_nxt;

  logic                  item_accept;
  logic                  pt_valid;
  logic [COORD_BITS-1:0] pt_cx, pt_cy, pt_a, pt_b;
  logic                  pt_done;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [QW-1:0]         q_rd_data;
  logic                  out_valid;
  logic [PIX_W-1:0]      pix_x, pix_y;
  pix_flags_t            pix_flags;

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_comb begin
    img_width_nxt  = img_width_r;
    img_height_nxt = img_height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  img_width_nxt  = cfg_data;
        CFG_IMAGE_HEIGHT: img_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= IMG_DIM_RESET;
      img_height_r <= IMG_DIM_RESET;
    end else begin
      img_width_r  <= img_width_nxt;
      img_height_r <= img_height_nxt;
    end
  end

  // Every item, start or step, is gated on a free queue slot.
  assign full        = q_full;
  assign item_accept = push && !q_full;

  mcr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (item_accept),
    .req_type    (in_req_type),
    .center_x    (in_center_x),
    .center_y    (in_center_y),
    .radius      (in_radius),
    .pt_valid    (pt_valid),
    .pt_cx       (pt_cx),
    .pt_cy       (pt_cy),
    .pt_a        (pt_a),
    .pt_b        (pt_b),
    .pt_done     (pt_done)
  );

  mcr_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pt_valid),
    .push_data ({pt_cx, pt_cy, pt_a, pt_b, pt_done}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .valid     (q_valid)
  );

  mcr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_cx        (q_rd_data[QW-1 -: COORD_BITS]),
    .q_cy        (q_rd_data[QW-1-COORD_BITS -: COORD_BITS]),
    .q_a         (q_rd_data[QW-1-2*COORD_BITS -: COORD_BITS]),
    .q_b         (q_rd_data[COORD_BITS:1]),
    .q_done      (q_rd_data[0]),
    .q_pop       (q_pop),
    .img_width   (img_width_r),
    .img_height  (img_height_r),
    .out_pop     (pop),
    .out_valid   (out_valid),
    .out_pixel_x (pix_x),
    .out_pixel_y (pix_y),
    .out_flags   (pix_flags)
  );

  assign empty             = !out_valid;
  assign out_pixel_x       = $signed(pix_x);
  assign out_pixel_y       = $signed(pix_y);
  assign out_in_image      = pix_flags.in_image;
  assign out_last_of_point = pix_flags.last_of_point;
  assign out_circle_done   = pix_flags.circle_done;

  // The end of a circle is only ever flagged on the closing pixel of a point.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_circle_done) |-> out_last_of_point)
    else $error("circle_done without last_of_point");

  // The front end only issues a point when the queue had room for its item.
  assert property (@(posedge clk) disable iff (!rst_n)
    pt_valid |-> !q_full)
    else $error("point record pushed into a full queue");

  // A pixel flagged in-image never has a negative coordinate.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_in_image) |-> (!out_pixel_x[PIX_W-1] && !out_pixel_y[PIX_W-1]))
    else $error("negative coordinate flagged in-image");

  // Reset leaves no result waiting.
  assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

endmodule

// ===== bench/mcr_pixel_checker.sv =====
// Pixel stream checker for the midpoint circle rasterizer: predicts every pixel and compares it.
`timescale 1ns / 100ps
module mcr_pixel_checker import mcr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic                    full,
  input  logic                    in_req_type,
  input  logic [CTR_W-1:0]        in_center_x,
  input  logic [CTR_W-1:0]        in_center_y,
  input  logic [RAD_W-1:0]        in_radius,
  input  logic                    empty,
  input  logic                    pop,
  input  logic signed [PIX_W-1:0] out_pixel_x,
  input  logic signed [PIX_W-1:0] out_pixel_y,
  input  logic                    out_in_image,
  input  logic                    out_last_of_point,
  input  logic                    out_circle_done,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  output int                      fail_count,
  output int                      pixel_pending,
  output int                      pixels_checked
);

  typedef struct {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    pix_flags_t              flags;
  } pixel_t;

  logic [DIM_W-1:0]          img_w;
  logic [DIM_W-1:0]          img_h;
  logic [COORD_BITS_DEF-1:0] ctr_col;
  logic [COORD_BITS_DEF-1:0] ctr_row;
  logic [COORD_BITS_DEF-1:0] off_a;
  logic [COORD_BITS_DEF-1:0] off_b;
  logic signed [DEC_W-1:0]   decision;
  logic                      circle_live;
  pixel_t                    expected_pixels[$];

  function automatic void expect_pixel(int px, int py, logic last, logic done);
    pixel_t p;
    p.x = px[PIX_W-1:0];
    p.y = py[PIX_W-1:0];
    p.flags.in_image      = px >= 0 && py >= 0 && px < int'(img_w) && py < int'(img_h);
    p.flags.last_of_point = last;
    p.flags.circle_done   = done;
    expected_pixels.push_back(p);
  endfunction

  function automatic void start_circle();
    ctr_col     = in_center_x;
    ctr_row     = in_center_y;
    off_a       = '0;
    off_b       = COORD_BITS_DEF'(in_radius);
    decision    = DEC_W'(3 - 2 * int'(in_radius));
    circle_live = 1'b1;
  endfunction

  // One step: eight symmetric pixels of the current offsets, then the midpoint update.
  function automatic void advance_circle();
    int   cx, cy, a, b, a_next, b_next, d;
    logic done;
    int   xs[8];
    int   ys[8];
    cx = ctr_col;
    cy = ctr_row;
    a  = off_a;
    b  = off_b;
    d  = decision;
    b_next = b;
    if (d < 0) begin
      d = d + 4 * a + 6;
    end else begin
      d = d + 4 * (a - b) + 10;
      b_next = b - 1;
    end
    a_next = a + 1;
    done   = a_next > b_next;
    xs = '{cx + a, cx - a, cx + a, cx - a, cx + b, cx - b, cx + b, cx - b};
    ys = '{cy + b, cy + b, cy - b, cy - b, cy + a, cy + a, cy - a, cy - a};
    for (int k = 0; k < 8; k++) begin
      expect_pixel(xs[k], ys[k], k == 7, k == 7 && done);
    end
    decision = d[DEC_W-1:0];
    off_a    = a_next[COORD_BITS_DEF-1:0];
    off_b    = b_next[COORD_BITS_DEF-1:0];
    if (done) begin
      circle_live = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      img_w       = IMG_DIM_RESET;
      img_h       = IMG_DIM_RESET;
      ctr_col     = '0;
      ctr_row     = '0;
      off_a       = '0;
      off_b       = '0;
      decision    = '0;
      circle_live = 1'b0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IMAGE_WIDTH) begin
          img_w = cfg_data;
        end else begin
          img_h = cfg_data;
        end
      end
      if (push && !full) begin
        if (in_req_type == REQ_START) begin
          start_circle();
        end else if (circle_live) begin
          advance_circle();
        end
      end
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $error("pixel (%0d, %0d) transferred with no pixel expected", out_pixel_x,
                 out_pixel_y);
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (out_pixel_x !== want.x) begin
            fail_count++;
            $error("pixel_x: expected %0d, got %0d", want.x, out_pixel_x);
          end
          if (out_pixel_y !== want.y) begin
            fail_count++;
            $error("pixel_y: expected %0d, got %0d", want.y, out_pixel_y);
          end
          if (out_in_image !== want.flags.in_image) begin
            fail_count++;
            $error("in_image: expected %0b, got %0b", want.flags.in_image, out_in_image);
          end
          if (out_last_of_point !== want.flags.last_of_point) begin
            fail_count++;
            $error("last_of_point: expected %0b, got %0b", want.flags.last_of_point,
                   out_last_of_point);
          end
          if (out_circle_done !== want.flags.circle_done) begin
            fail_count++;
            $error("circle_done: expected %0b, got %0b", want.flags.circle_done,
                   out_circle_done);
          end
        end
      end
    end
    pixel_pending <= expected_pixels.size();
  end

endmodule

// ===== bench/midpoint_circle_rasterizer_unit_test.sv =====
// Top of the midpoint circle rasterizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module midpoint_circle_rasterizer_unit_test;
  import mcr_pkg::*;

  // Random items per image size setting; with the directed part, five settings give
  // about 230 items.
  localparam int PHASE_ITEMS   = 38;
  // Cycles the receiver refuses pixels in the back-pressure phase.
  localparam int LONG_HOLD     = 200;
  // Quiet cycles after the last expected pixel, so that a start or an ignored
  // step still inside the front end has drained before the next size write.
  localparam int SETTLE_CYCLES = 32;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    push          = 1'b0;
  logic                    full;
  logic                    in_req_type   = REQ_START;
  logic [CTR_W-1:0]        in_center_x   = '0;
  logic [CTR_W-1:0]        in_center_y   = '0;
  logic [RAD_W-1:0]        in_radius     = '0;
  logic                    empty;
  logic                    pop           = 1'b0;
  logic signed [PIX_W-1:0] out_pixel_x;
  logic signed [PIX_W-1:0] out_pixel_y;
  logic                    out_in_image;
  logic                    out_last_of_point;
  logic                    out_circle_done;
  logic                    cfg_valid     = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index     = CFG_IMAGE_WIDTH;
  logic [DIM_W-1:0]        cfg_data      = '0;

  int fail_count;
  int pixel_pending;
  int pixels_checked;

  // Stimulus bookkeeping; the receiver process only reads idle_on and hold_requests.
  bit idle_on       = 1'b1;
  int hold_requests = 0;
  int items_sent    = 0;
  int circles_begun = 0;
  int sizes_used    = 0;

  midpoint_circle_rasterizer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_req_type      (in_req_type),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius        (in_radius),
    .empty            (empty),
    .pop              (pop),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_in_image     (out_in_image),
    .out_last_of_point(out_last_of_point),
    .out_circle_done  (out_circle_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // The checker sits beside the block and watches every transfer on all three ports.
  mcr_pixel_checker pixel_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_req_type      (in_req_type),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius        (in_radius),
    .empty            (empty),
    .pop              (pop),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_in_image     (out_in_image),
    .out_last_of_point(out_last_of_point),
    .out_circle_done  (out_circle_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pixel_pending    (pixel_pending),
    .pixels_checked   (pixels_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // A run that has not finished by this time is reported as failed.
  initial begin
    #4_000_000;
    $display("midpoint_circle_rasterizer_unit_test failed");
    $finish;
  end

  // Pixel receiver. It pops at full rate, drops out in random bursts while idling
  // is enabled, and once per request refuses pixels for a long stretch so that the
  // point queue fills and full pushes back on the sender.
  initial begin : receiver
    int hold_seen;
    int burst;
    hold_seen = 0;
    forever begin
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12);
        pop <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one item and returns at the edge where it transfers. Push stays high
  // between back-to-back items; an idle burst lowers it first.
  task automatic send_item(req_t kind, logic [CTR_W-1:0] cx, logic [CTR_W-1:0] cy,
                           logic [RAD_W-1:0] r);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    in_req_type <= kind;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius   <= r;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // Step items carry random centre and radius bits, which the block must ignore.
  task automatic send_step();
    send_item(REQ_STEP, CTR_W'($urandom_range(0, 1023)), CTR_W'($urandom_range(0, 1023)),
              RAD_W'($urandom_range(0, 511)));
  endtask

  // Centres are biased toward both ends of the coordinate range so that small
  // circles straddle the image borders, whatever size the image has.
  function automatic logic [CTR_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return CTR_W'($urandom_range(0, 15));
      1:       return CTR_W'($urandom_range(1008, 1023));
      default: return CTR_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Drops push, waits until every predicted pixel has transferred, then lets the
  // front end settle. The pending count is read at the falling edge, where it is stable.
  task automatic wait_idle();
    push <= 1'b0;
    do @(negedge clk); while (pixel_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both image size registers; valid stays high across the two transfers.
  task automatic set_image_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sizes_used++;
  endtask

  // One circle sequence. Most are small circles stepped to completion, sometimes
  // with a surplus step that the block ignores. Some are abandoned partway by the
  // next start, and a few use the full radius range with only a handful of steps.
  task automatic random_circle();
    logic [RAD_W-1:0] r;
    int               steps;
    int               pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      r     = RAD_W'($urandom_range(0, 511));
      steps = $urandom_range(0, 4);
    end else begin
      r     = RAD_W'($urandom_range(0, 15));
      steps = (int'(r) * 181) / 256 + 2;
      if (pick == 1) begin
        steps = $urandom_range(0, steps);
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      send_step();
    end
    send_item(REQ_START, pick_coord(), pick_coord(), r);
    circles_begun++;
    repeat (steps) send_step();
  endtask

  task automatic run_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    int target;
    wait_idle();
    set_image_size(w, h);
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      random_circle();
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset image size of 750 by 750.
    // A step before any circle exists is swallowed.
    send_step();
    // Zero radius at the origin: the centre eight times, then the circle is done,
    // and the following step has no circle left to advance.
    send_item(REQ_START, '0, '0, '0);
    circles_begun++;
    send_step();
    send_step();
    // Largest centre and radius: most pixels fall off the image, and the coordinates
    // reach 1534, the largest the block can produce.
    send_item(REQ_START, '1, '1, '1);
    circles_begun++;
    send_step();
    send_step();
    // A small circle traced to its end, through both branches of the update.
    send_item(REQ_START, 10'd5, 10'd7, 9'd3);
    circles_begun++;
    repeat (3) send_step();
    // A start on a live circle abandons it; the radius-one circle then finishes
    // in a single step and the surplus step is swallowed.
    send_item(REQ_START, 10'd300, 10'd2, 9'd20);
    circles_begun++;
    send_step();
    send_item(REQ_START, 10'd1, 10'd1, 9'd1);
    circles_begun++;
    send_step();
    send_step();
    // Near the middle, with negative offsets reaching below zero on neither axis.
    send_item(REQ_START, 10'd512, 10'd512, 9'd256);
    circles_begun++;
    send_step();
    send_step();

    // Random part, one image size per phase, the extremes among them.
    run_phase(11'd1024, 11'd1024);
    // Back-pressure phase: once the block has drained, the receiver stops for a
    // long stretch while the sender keeps offering items into a full block.
    wait_idle();
    hold_requests++;
    run_phase(11'd0, 11'd2047);
    run_phase(11'd1, 11'd1);
    run_phase(11'd2047, 11'd0);
    // The last part runs with neither side idling.
    idle_on = 1'b0;
    run_phase(DIM_W'($urandom_range(1, 1024)), DIM_W'($urandom_range(1, 1024)));

    wait_idle();
    $display("Sent %0d items over %0d circles and %0d image sizes; %0d pixels checked.",
             items_sent, circles_begun, sizes_used, pixels_checked);
    $display("Included zero radius, abandoned circles, swallowed steps, off-image pixels",
             " and a long receiver stall.");
    if (fail_count == 0 && pixel_pending == 0) begin
      $display("midpoint_circle_rasterizer_unit_test passed");
    end else begin
      $display("midpoint_circle_rasterizer_unit_test failed");
    end
    $finish;
  end

endmodule
